// ===== sv/address_region_map_defines.svh =====
// ----------------------------------------------------------------------------
// Address region map assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_REGION_MAP_DEFINES_SVH
`define ADDRESS_REGION_MAP_DEFINES_SVH

// same-cycle implication
`define ARM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("address_region_map check failed");

// next-cycle implication
`define ARM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("address_region_map check failed");

`endif

// ===== sv/arm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address region map package
// Shared widths, operation and status codes, and the token control struct.
// ----------------------------------------------------------------------------
package arm_pkg;

	localparam int MAX_REGIONS_DEF = 16;
	localparam int ADDR_BITS_DEF   = 32;
	localparam int PORT_AW         = 32;
	localparam int TYPE_W          = 8;
	localparam int HAND_W          = 8;

	typedef enum logic [1:0] {
		MODE_INSERT    = 2'd0,
		MODE_REMOVE    = 2'd1,
		MODE_LOOKUP    = 2'd2,
		MODE_TRANSLATE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOTREG  = 2'd3
	} status_t;

	// control part of the token that walks the cell chain
	typedef struct packed {
		logic    act;
		logic    done;
		mode_t   mode;
		status_t status;
		logic    hit;
		logic    shift;
		logic    has_prev;
	} tok_ctl_t;

endpackage

// ===== sv/arm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address region map request channel
// Valid/ready channel carrying one operation per transaction.
// ----------------------------------------------------------------------------
interface arm_req_if;
	import arm_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          mode;
	logic [TYPE_W-1:0]   region_type;
	logic [PORT_AW-1:0]  range_start;
	logic [PORT_AW-1:0]  range_end;
	logic [HAND_W-1:0]   handler_id;
	logic [PORT_AW-1:0]  address;

	modport source (
		output valid, mode, region_type, range_start, range_end, handler_id, address,
		input  ready
	);

	modport sink (
		input  valid, mode, region_type, range_start, range_end, handler_id, address,
		output ready
	);

endinterface

// ===== sv/arm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address region map response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface arm_rsp_if;
	import arm_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic                hit;
	logic [TYPE_W-1:0]   found_type;
	logic [HAND_W-1:0]   found_handler;
	logic [PORT_AW-1:0]  real_address;

	modport source (
		output valid, status, hit, found_type, found_handler, real_address,
		input  ready
	);

	modport sink (
		input  valid, status, hit, found_type, found_handler, real_address,
		output ready
	);

endinterface

// ===== sv/arm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address region map cell
// Holds one region slot and one stage of the operation token. Inserts shift
// entries toward the tail through the token, removes pull from the next cell.
// ----------------------------------------------------------------------------
module arm_cell #(
	parameter int AW = arm_pkg::ADDR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  arm_pkg::tok_ctl_t           ti_ctl,
	input  logic [arm_pkg::TYPE_W-1:0]  ti_type,
	input  logic [AW-1:0]               ti_start,
	input  logic [AW-1:0]               ti_end,
	input  logic [arm_pkg::HAND_W-1:0]  ti_hand,
	input  logic [AW-1:0]               ti_addr,
	input  logic [AW-1:0]               ti_pend,
	input  logic [AW-1:0]               ti_real,
	output arm_pkg::tok_ctl_t           to_ctl,
	output logic [arm_pkg::TYPE_W-1:0]  to_type,
	output logic [AW-1:0]               to_start,
	output logic [AW-1:0]               to_end,
	output logic [arm_pkg::HAND_W-1:0]  to_hand,
	output logic [AW-1:0]               to_addr,
	output logic [AW-1:0]               to_pend,
	output logic [AW-1:0]               to_real,
	input  logic                        nx_valid,
	input  logic [arm_pkg::TYPE_W-1:0]  nx_type,
	input  logic [AW-1:0]               nx_start,
	input  logic [AW-1:0]               nx_end,
	input  logic [arm_pkg::HAND_W-1:0]  nx_hand,
	output logic                        my_valid,
	output logic [arm_pkg::TYPE_W-1:0]  my_type,
	output logic [AW-1:0]               my_start,
	output logic [AW-1:0]               my_end,
	output logic [arm_pkg::HAND_W-1:0]  my_hand
);
	import arm_pkg::*;

	logic               v_q;
	logic [TYPE_W-1:0]  type_q;
	logic [AW-1:0]      start_q;
	logic [AW-1:0]      end_q;
	logic [HAND_W-1:0]  hand_q;

	tok_ctl_t           ctl_q, ctl_d;
	logic [TYPE_W-1:0]  ttype_q, ttype_d;
	logic [AW-1:0]      tstart_q, tstart_d;
	logic [AW-1:0]      tend_q, tend_d;
	logic [HAND_W-1:0]  thand_q, thand_d;
	logic [AW-1:0]      taddr_q;
	logic [AW-1:0]      tpend_q, tpend_d;
	logic [AW-1:0]      treal_q, treal_d;

	logic le, ovl, wr_tok, wr_nxt;

	always_comb begin
		ctl_d    = ti_ctl;
		ttype_d  = ti_type;
		tstart_d = ti_start;
		tend_d   = ti_end;
		thand_d  = ti_hand;
		tpend_d  = ti_pend;
		treal_d  = ti_real;
		wr_tok   = 1'b0;
		wr_nxt   = 1'b0;
		le  = v_q && (start_q <= ti_start);
		ovl = (ti_ctl.has_prev && (ti_start <= ti_pend)) || (v_q && (ti_end >= start_q));
		if (ti_ctl.act && !ti_ctl.done) begin
			case (ti_ctl.mode)
				MODE_INSERT: begin
					if (ti_ctl.shift || (!le && !ovl)) begin
						// take the carried entry, pass the old one on
						wr_tok       = 1'b1;
						ctl_d.shift  = 1'b1;
						ctl_d.done   = !v_q;
						ttype_d      = type_q;
						tstart_d     = start_q;
						tend_d       = end_q;
						thand_d      = hand_q;
					end else if (le) begin
						ctl_d.has_prev = 1'b1;
						tpend_d        = end_q;
					end else begin
						ctl_d.done   = 1'b1;
						ctl_d.status = ST_OVERLAP;
					end
				end
				MODE_REMOVE: begin
					if (ti_ctl.shift || (v_q && (hand_q == ti_hand))) begin
						wr_nxt      = 1'b1;
						ctl_d.shift = 1'b1;
						ctl_d.done  = !nx_valid;
					end else if (!v_q) begin
						ctl_d.done = 1'b1;
					end
				end
				MODE_LOOKUP: begin
					if (!v_q) begin
						ctl_d.done = 1'b1;
					end else if ((ti_addr >= start_q) && (ti_addr < end_q)) begin
						ctl_d.hit  = 1'b1;
						ctl_d.done = 1'b1;
						ttype_d    = type_q;
						thand_d    = hand_q;
					end
				end
				MODE_TRANSLATE: begin
					if (!v_q) begin
						ctl_d.done = 1'b1;
					end else if (type_q == ti_type) begin
						ctl_d.done   = 1'b1;
						ctl_d.status = ST_OK;
						treal_d      = start_q + ti_addr;
					end
				end
				default: begin
					ctl_d.done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_d;
			if (wr_tok) begin
				v_q <= 1'b1;
			end else if (wr_nxt) begin
				v_q <= nx_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ttype_q  <= ttype_d;
			tstart_q <= tstart_d;
			tend_q   <= tend_d;
			thand_q  <= thand_d;
			taddr_q  <= ti_addr;
			tpend_q  <= tpend_d;
			treal_q  <= treal_d;
			if (wr_tok) begin
				type_q  <= ti_type;
				start_q <= ti_start;
				end_q   <= ti_end;
				hand_q  <= ti_hand;
			end else if (wr_nxt) begin
				type_q  <= nx_type;
				start_q <= nx_start;
				end_q   <= nx_end;
				hand_q  <= nx_hand;
			end
		end
	end

	assign to_ctl   = ctl_q;
	assign to_type  = ttype_q;
	assign to_start = tstart_q;
	assign to_end   = tend_q;
	assign to_hand  = thand_q;
	assign to_addr  = taddr_q;
	assign to_pend  = tpend_q;
	assign to_real  = treal_q;

	assign my_valid = v_q;
	assign my_type  = type_q;
	assign my_start = start_q;
	assign my_end   = end_q;
	assign my_hand  = hand_q;

endmodule

// ===== sv/address_region_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address region map
// Sorted table of non-overlapping address regions with insert, remove,
// lookup and translate operations.
//
// Usage:
//   req carries one operation per transaction (mode, region_type, range_start,
//   range_end, handler_id, address); rsp returns exactly one result for each.
//   The table is a row of MAX_REGIONS cells, one slot each. An accepted
//   operation becomes a token that steps one cell per cycle down the row
//   while the row is not frozen; its result is registered onto rsp as it
//   leaves the last cell. One operation is in the row at a time: req.ready
//   drops after acceptance and rises once the result is registered, so no
//   new operation is taken before the last one is through. A new request
//   may be accepted while the previous result still waits on rsp.
//   If rsp is stalled when the next token reaches the end of the row, the
//   whole row freezes until the pending result is taken.
//   Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module address_region_map #(
	parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF,
	parameter int ADDR_BITS   = arm_pkg::ADDR_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	arm_req_if.sink   req,
	arm_rsp_if.source rsp
);
	import arm_pkg::*;

	tok_ctl_t            c_ctl   [MAX_REGIONS+1];
	logic [TYPE_W-1:0]   c_type  [MAX_REGIONS+1];
	logic [ADDR_BITS-1:0] c_start [MAX_REGIONS+1];
	logic [ADDR_BITS-1:0] c_end   [MAX_REGIONS+1];
	logic [HAND_W-1:0]   c_hand  [MAX_REGIONS+1];
	logic [ADDR_BITS-1:0] c_addr  [MAX_REGIONS+1];
	logic [ADDR_BITS-1:0] c_pend  [MAX_REGIONS+1];
	logic [ADDR_BITS-1:0] c_real  [MAX_REGIONS+1];

	logic                s_valid [MAX_REGIONS+1];
	logic [TYPE_W-1:0]   s_type  [MAX_REGIONS+1];
	logic [ADDR_BITS-1:0] s_start [MAX_REGIONS+1];
	logic [ADDR_BITS-1:0] s_end   [MAX_REGIONS+1];
	logic [HAND_W-1:0]   s_hand  [MAX_REGIONS+1];

	tok_ctl_t  inj_ctl;
	mode_t     in_mode;
	mode_t     out_mode;
	logic      accept, en, exit_tok;
	logic      busy_q;
	logic      rsp_v_q;
	status_t   status_q;
	logic      hit_q;
	logic [TYPE_W-1:0]  ftype_q;
	logic [HAND_W-1:0]  fhand_q;
	logic [PORT_AW-1:0] real_q;

	assign in_mode  = mode_t'(req.mode);
	assign accept   = req.valid && req.ready;
	assign req.ready = !busy_q;

	assign out_mode = c_ctl[MAX_REGIONS].mode;
	assign en       = !c_ctl[MAX_REGIONS].act || !rsp_v_q || rsp.ready;
	assign exit_tok = c_ctl[MAX_REGIONS].act && en;

	always_comb begin
		inj_ctl        = '0;
		inj_ctl.act    = accept;
		inj_ctl.mode   = in_mode;
		inj_ctl.status = (in_mode == MODE_TRANSLATE) ? ST_NOTREG : ST_OK;
		// last slot in use means the table is full
		if ((in_mode == MODE_INSERT) && s_valid[MAX_REGIONS-1]) begin
			inj_ctl.done   = 1'b1;
			inj_ctl.status = ST_FULL;
		end
	end

	assign c_ctl[0]   = inj_ctl;
	assign c_type[0]  = (in_mode == MODE_LOOKUP) ? '0 : req.region_type;
	assign c_start[0] = ADDR_BITS'(req.range_start);
	assign c_end[0]   = ADDR_BITS'(req.range_end);
	assign c_hand[0]  = (in_mode == MODE_LOOKUP) ? '0 : req.handler_id;
	assign c_addr[0]  = ADDR_BITS'(req.address);
	assign c_pend[0]  = '0;
	assign c_real[0]  = '0;

	assign s_valid[MAX_REGIONS] = 1'b0;
	assign s_type[MAX_REGIONS]  = '0;
	assign s_start[MAX_REGIONS] = '0;
	assign s_end[MAX_REGIONS]   = '0;
	assign s_hand[MAX_REGIONS]  = '0;

	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
		arm_cell #(
			.AW(ADDR_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ti_ctl   (c_ctl[i]),
			.ti_type  (c_type[i]),
			.ti_start (c_start[i]),
			.ti_end   (c_end[i]),
			.ti_hand  (c_hand[i]),
			.ti_addr  (c_addr[i]),
			.ti_pend  (c_pend[i]),
			.ti_real  (c_real[i]),
			.to_ctl   (c_ctl[i+1]),
			.to_type  (c_type[i+1]),
			.to_start (c_start[i+1]),
			.to_end   (c_end[i+1]),
			.to_hand  (c_hand[i+1]),
			.to_addr  (c_addr[i+1]),
			.to_pend  (c_pend[i+1]),
			.to_real  (c_real[i+1]),
			.nx_valid (s_valid[i+1]),
			.nx_type  (s_type[i+1]),
			.nx_start (s_start[i+1]),
			.nx_end   (s_end[i+1]),
			.nx_hand  (s_hand[i+1]),
			.my_valid (s_valid[i]),
			.my_type  (s_type[i]),
			.my_start (s_start[i]),
			.my_end   (s_end[i]),
			.my_hand  (s_hand[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rsp_v_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exit_tok) begin
				busy_q <= 1'b0;
			end
			if (exit_tok) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_tok) begin
			status_q <= c_ctl[MAX_REGIONS].status;
			hit_q    <= c_ctl[MAX_REGIONS].hit;
			ftype_q  <= (out_mode == MODE_LOOKUP) ? c_type[MAX_REGIONS] : '0;
			fhand_q  <= (out_mode == MODE_LOOKUP) ? c_hand[MAX_REGIONS] : '0;
			real_q   <= PORT_AW'(c_real[MAX_REGIONS]);
		end
	end

	assign rsp.valid         = rsp_v_q;
	assign rsp.status        = status_q;
	assign rsp.hit           = hit_q;
	assign rsp.found_type    = ftype_q;
	assign rsp.found_handler = fhand_q;
	assign rsp.real_address  = real_q;

endmodule

// ===== sv/arm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address region map port checker
// Concurrent checks on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "address_region_map_defines.svh"

module arm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [1:0]                  status,
	input logic                        hit,
	input logic [arm_pkg::TYPE_W-1:0]  found_type,
	input logic [arm_pkg::HAND_W-1:0]  found_handler,
	input logic [arm_pkg::PORT_AW-1:0] real_address
);
	import arm_pkg::*;

	`ARM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({status, hit, found_type, found_handler, real_address}))
	`ARM_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
	`ARM_ASSERT_NOW(a_miss_fields, rsp_valid && !hit, (found_type == '0) && (found_handler == '0))
	`ARM_ASSERT_NOW(a_hit_status, rsp_valid && hit, (status == ST_OK) && (real_address == '0))
	`ARM_ASSERT_NOW(a_notreg_fields, rsp_valid && (status == ST_NOTREG), (real_address == '0) && !hit)

endmodule

bind address_region_map arm_checker u_arm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.hit           (rsp.hit),
	.found_type    (rsp.found_type),
	.found_handler (rsp.found_handler),
	.real_address  (rsp.real_address)
);
